/* design/lapm_arq_window_controller_macros.svh */
// assertion macros for the lapm arq window controller
// no dependencies; included by the top level
`ifndef LAPM_ARQ_WINDOW_CONTROLLER_MACROS_SVH
`define LAPM_ARQ_WINDOW_CONTROLLER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LAPM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lapm assertion failed");
`define LAPM_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("lapm forbidden condition");
`else
`define LAPM_ASSERT(label, clk, rst_n, prop)
`define LAPM_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* design/lapm_pkg.sv */
// constants and codes for the lapm arq window controller
// no dependencies
package lapm_pkg;
	localparam int SEQ_W = 7;
	localparam int SEQ_SLOTS = 128;
	localparam int DEF_WINDOW_SIZE = 15;
	localparam int DEF_CHUNK_BYTES = 128;
	localparam int DEF_RX_DEPTH = 8192;
	localparam logic [15:0] DEF_TIMEOUT_MS = 16'd1000;
	localparam logic [7:0] DEF_RETRY_LIMIT = 8'd3;

	// request codes
	localparam logic [2:0] REQ_WRITE = 3'd0;
	localparam logic [2:0] REQ_READ = 3'd1;
	localparam logic [2:0] REQ_RECV = 3'd2;
	localparam logic [2:0] REQ_NEXT = 3'd3;
	localparam logic [2:0] REQ_TICK = 3'd4;

	// received frame kinds
	localparam logic [2:0] FK_I = 3'd0;
	localparam logic [2:0] FK_RR = 3'd1;
	localparam logic [2:0] FK_RNR = 3'd2;
	localparam logic [2:0] FK_REJ = 3'd3;
	localparam logic [2:0] FK_SREJ = 3'd4;

	// supervisory kinds held pending
	localparam logic [1:0] SUP_RR = 2'd1;
	localparam logic [1:0] SUP_RNR = 2'd2;
	localparam logic [1:0] SUP_REJ = 2'd3;

	// send kinds and rx status
	localparam logic [2:0] SK_NONE = 3'd0;
	localparam logic [2:0] SK_I = 3'd4;
	localparam logic [1:0] RXS_NONE = 2'd0;
	localparam logic [1:0] RXS_DELIVERED = 2'd1;
	localparam logic [1:0] RXS_ERROR = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_CR = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_RETRY = 2'd2;
endpackage

/* design/lapm_ram.sv */
// generic two-port ram, one write port, one registered read port
// no dependencies
module lapm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* design/lapm_arq_window_controller.sv */
// top level of the lapm arq window controller: sequencer, state and shared 32-bit adder
// depends on lapm_pkg, lapm_ram and lapm_arq_window_controller_macros.svh
// a request is taken when start is high and busy low; it goes through dispatch and finish,
// and also tick check for tick, next out for next with an I frame, rx post for a receive
// with its ack ignored, write over its chunks for write, and ack walk over the freed slots
// (at most the window), ack end and rx post for an acknowledged receive.
// one request at a time. reset clears all sequence state and slot valid bits, not lengths.
`include "lapm_arq_window_controller_macros.svh"
module lapm_arq_window_controller
	import lapm_pkg::*;
#(
	parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
	parameter int CHUNK_BYTES = DEF_CHUNK_BYTES,
	parameter int RX_DEPTH = DEF_RX_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] req_type,
	input logic [15:0] byte_count,
	input logic frame_valid,
	input logic [2:0] frame_kind,
	input logic [6:0] frame_send_seq,
	input logic [6:0] frame_recv_seq,
	input logic [7:0] frame_info_len,
	input logic [15:0] elapsed_ms,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	output logic result_valid,
	output logic [15:0] bytes_done,
	output logic [1:0] rx_status,
	output logic [2:0] send_kind,
	output logic [6:0] send_seq,
	output logic [6:0] send_ack_seq,
	output logic send_cr,
	output logic [7:0] send_len,
	output logic [6:0] unacked_frames,
	output logic link_failed
);
	localparam int OCC_W = $clog2(RX_DEPTH);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DISPATCH = 4'd1;
	localparam logic [3:0] ST_WRITE = 4'd2;
	localparam logic [3:0] ST_ACK_WALK = 4'd3;
	localparam logic [3:0] ST_ACK_END = 4'd4;
	localparam logic [3:0] ST_RX_POST = 4'd5;
	localparam logic [3:0] ST_NEXT_OUT = 4'd6;
	localparam logic [3:0] ST_TICK_CHK = 4'd7;
	localparam logic [3:0] ST_FINISH = 4'd8;

	logic [3:0] state_q;

	// latched request
	logic [2:0] req_q;
	logic [15:0] count_q;
	logic fvalid_q;
	logic [2:0] fkind_q;
	logic [6:0] fns_q;
	logic [6:0] fnr_q;
	logic [7:0] flen_q;
	logic [15:0] elapsed_q;

	// configuration
	logic cr_q;
	logic [15:0] timeout_q;
	logic [7:0] retry_limit_q;

	// link state
	logic [6:0] ack_base_q;
	logic [6:0] nss_q;
	logic [6:0] recv_seq_q;
	logic [6:0] cursor_q;
	logic [SEQ_SLOTS-1:0] slot_valid_q;
	logic [OCC_W-1:0] occ_q;
	logic [31:0] now_q;
	logic [31:0] deadline_q;
	logic [7:0] retry_q;
	logic failed_q;
	logic [1:0] sup_kind_q;
	logic sup_flag_q;

	// result registers
	logic res_valid_q;
	logic [15:0] done_q;
	logic [1:0] rxs_q;
	logic [2:0] skind_q;
	logic [6:0] sseq_q;
	logic [6:0] sack_q;
	logic scr_q;
	logic [7:0] slen_q;
	logic [6:0] unacked_q;
	logic failed_out_q;

	// shared adder: tick time advance, or now plus timeout for a fresh deadline
	logic [31:0] alu_b;
	logic [31:0] alu_sum;
	assign alu_b = (state_q == ST_DISPATCH) ? {16'd0, elapsed_q} : {16'd0, timeout_q};
	assign alu_sum = now_q + alu_b;

	logic [6:0] outstanding;
	logic [6:0] nr_dist;
	logic [6:0] cur_dist;
	logic [15:0] remain;
	logic [7:0] chunk;
	logic [15:0] occ_ext;
	logic [16:0] rx_need;
	logic ram_we;
	logic [7:0] ram_rdata;

	assign outstanding = nss_q - ack_base_q;
	assign nr_dist = fnr_q - ack_base_q;
	assign cur_dist = cursor_q - ack_base_q;
	assign remain = count_q - done_q;
	assign chunk = (remain > 16'(CHUNK_BYTES)) ? 8'(CHUNK_BYTES) : remain[7:0];
	assign occ_ext = 16'(occ_q);
	assign rx_need = 17'(flen_q) + 17'(occ_q);
	assign ram_we = (state_q == ST_WRITE) && (done_q < count_q) &&
		(outstanding < 7'(WINDOW_SIZE));

	lapm_ram #(
		.WIDTH(8),
		.DEPTH(SEQ_SLOTS)
	) u_slot_len (
		.clk(clk),
		.we(ram_we),
		.waddr(nss_q),
		.wdata(chunk),
		.raddr(cursor_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req_type;
			count_q <= byte_count;
			fvalid_q <= frame_valid;
			fkind_q <= frame_kind;
			fns_q <= frame_send_seq;
			fnr_q <= frame_recv_seq;
			flen_q <= frame_info_len;
			elapsed_q <= elapsed_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_q <= 1'b0;
			timeout_q <= DEF_TIMEOUT_MS;
			retry_limit_q <= DEF_RETRY_LIMIT;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CR: cr_q <= cfg_data[0];
				CFG_TIMEOUT: timeout_q <= cfg_data;
				CFG_RETRY: retry_limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ack_base_q <= '0;
			nss_q <= '0;
			recv_seq_q <= '0;
			cursor_q <= '0;
			slot_valid_q <= '0;
			occ_q <= '0;
			now_q <= '0;
			deadline_q <= '0;
			retry_q <= '0;
			failed_q <= 1'b0;
			sup_kind_q <= '0;
			sup_flag_q <= 1'b0;
			res_valid_q <= 1'b0;
			done_q <= '0;
			rxs_q <= '0;
			skind_q <= '0;
			sseq_q <= '0;
			sack_q <= '0;
			scr_q <= 1'b0;
			slen_q <= '0;
			unacked_q <= '0;
			failed_out_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					done_q <= '0;
					rxs_q <= RXS_NONE;
					skind_q <= SK_NONE;
					sseq_q <= '0;
					sack_q <= '0;
					scr_q <= 1'b0;
					slen_q <= '0;
					state_q <= ST_FINISH;
					case (req_q)
						REQ_WRITE: state_q <= ST_WRITE;
						REQ_READ: begin
							if (count_q < occ_ext) begin
								done_q <= count_q;
								occ_q <= occ_q - OCC_W'(count_q);
							end else begin
								done_q <= occ_ext;
								occ_q <= '0;
							end
						end
						REQ_RECV: begin
							if (!fvalid_q) begin
								rxs_q <= RXS_ERROR;
							end else if (fkind_q == FK_I || fkind_q == FK_RR ||
								fkind_q == FK_RNR || fkind_q == FK_REJ) begin
								// acknowledgement outside the outstanding range is ignored
								state_q <= (nr_dist > outstanding) ? ST_RX_POST : ST_ACK_WALK;
							end else if (fkind_q == FK_SREJ) begin
								if (slot_valid_q[fnr_q]) begin
									cursor_q <= fnr_q;
								end
							end
						end
						REQ_NEXT: begin
							if (sup_flag_q) begin
								sup_flag_q <= 1'b0;
								skind_q <= {1'b0, sup_kind_q};
								sack_q <= recv_seq_q;
								scr_q <= cr_q;
							end else if (cursor_q != nss_q && slot_valid_q[cursor_q]) begin
								state_q <= ST_NEXT_OUT;
							end
						end
						REQ_TICK: begin
							now_q <= alu_sum;
							state_q <= ST_TICK_CHK;
						end
						default: ;
					endcase
				end
				ST_WRITE: begin
					if (ram_we) begin
						slot_valid_q[nss_q] <= 1'b1;
						nss_q <= nss_q + 7'd1;
						done_q <= done_q + 16'(chunk);
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_ACK_WALK: begin
					// one acknowledged slot released per cycle
					if (ack_base_q != fnr_q) begin
						slot_valid_q[ack_base_q] <= 1'b0;
						ack_base_q <= ack_base_q + 7'd1;
					end else begin
						state_q <= ST_ACK_END;
					end
				end
				ST_ACK_END: begin
					if (cur_dist > outstanding) begin
						cursor_q <= ack_base_q;
					end
					if (ack_base_q == nss_q) begin
						deadline_q <= '0;
						retry_q <= '0;
					end else begin
						deadline_q <= alu_sum;
					end
					state_q <= ST_RX_POST;
				end
				ST_RX_POST: begin
					if (fkind_q == FK_I) begin
						sup_flag_q <= 1'b1;
						if (fns_q != recv_seq_q) begin
							sup_kind_q <= (fns_q == recv_seq_q - 7'd1) ? SUP_RR : SUP_REJ;
						end else if (rx_need > 17'(RX_DEPTH - 1)) begin
							sup_kind_q <= SUP_RNR;
						end else begin
							occ_q <= occ_q + OCC_W'(flen_q);
							recv_seq_q <= recv_seq_q + 7'd1;
							sup_kind_q <= SUP_RR;
							rxs_q <= RXS_DELIVERED;
						end
					end else if (fkind_q == FK_REJ) begin
						cursor_q <= fnr_q;
					end
					state_q <= ST_FINISH;
				end
				ST_NEXT_OUT: begin
					skind_q <= SK_I;
					sseq_q <= cursor_q;
					sack_q <= recv_seq_q;
					scr_q <= cr_q;
					slen_q <= ram_rdata;
					cursor_q <= cursor_q + 7'd1;
					if (deadline_q == '0) begin
						deadline_q <= alu_sum;
					end
					state_q <= ST_FINISH;
				end
				ST_TICK_CHK: begin
					if (deadline_q != '0 && now_q >= deadline_q && ack_base_q != nss_q) begin
						if (retry_q != 8'hFF) begin
							retry_q <= retry_q + 8'd1;
						end
						if (retry_q >= retry_limit_q) begin
							failed_q <= 1'b1;
							deadline_q <= '0;
						end else begin
							cursor_q <= ack_base_q;
							deadline_q <= alu_sum;
						end
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					unacked_q <= outstanding;
					failed_out_q <= failed_q;
					res_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign result_valid = res_valid_q;
	assign bytes_done = done_q;
	assign rx_status = rxs_q;
	assign send_kind = skind_q;
	assign send_seq = sseq_q;
	assign send_ack_seq = sack_q;
	assign send_cr = scr_q;
	assign send_len = slen_q;
	assign unacked_frames = unacked_q;
	assign link_failed = failed_out_q;

	`LAPM_ASSERT(a_strobe_idle, clk, arst_n, result_valid |-> !busy)
	`LAPM_ASSERT(a_start_busy, clk, arst_n, (start && !busy) |=> busy)
	`LAPM_ASSERT(a_strobe_single, clk, arst_n, result_valid |=> !result_valid)
	`LAPM_NEVER(a_window, clk, arst_n, outstanding > 7'(WINDOW_SIZE))
endmodule
